### design/crcdf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the packet deframer.
// Used by crcdf_ctrl, crcdf_dp and crc16_packet_deframer; no dependencies.
`default_nettype none

package crcdf_pkg;

    // Largest payload a frame may carry and the widths that follow from it.
    localparam int MAX_PAYLOAD = 64;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 7;
    localparam int ADDR_W      = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] IDLE_SAT = 16'hFFFF;
    localparam logic [16:0] HB_SAT   = 17'h1FFFF;

    // Result kinds, carried on tuser.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ERROR   = 2'd1,
        KIND_LOST    = 2'd2
    } t_kind;

    // Framing error codes.
    typedef enum logic [1:0] {
        ERR_SYNC   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_CRC    = 2'd2,
        ERR_TERM   = 2'd3
    } t_err;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_SYNC0      = 3'd0,
        REG_SYNC1      = 3'd1,
        REG_SYNC2      = 3'd2,
        REG_SYNC3      = 3'd3,
        REG_TERM       = 3'd4,
        REG_FRAME_TO   = 3'd5,
        REG_HEARTBEAT  = 3'd6
    } t_reg_idx;

    // Input op codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  tick;
        logic  go_idle;
        logic  len_load;
        logic  pay_write;
        logic  crc_hi_load;
        logic  hb_clear;
        logic  burst_start;
        logic  rd_next;
        logic  out_load;
        t_kind out_kind;
        t_err  out_err;
        logic  out_len_sel;
        logic  out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sync0_eq;
        logic sync1_eq;
        logic sync2_eq;
        logic sync3_eq;
        logic term_eq;
        logic len_ok;
        logic crc_ok;
        logic pay_last;
        logic rd_last;
        logic idle_hit;
        logic hb_over;
        logic out_free;
    } t_dp_sts;

    // CRC-16/CCITT-FALSE update by one byte, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/crcdf_dp.sv
// Datapath of the packet deframer: configuration registers, CRC, timers,
// payload memory and the output register. Depends on crcdf_pkg.
`default_nettype none

module crcdf_dp (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  crcdf_pkg::t_dp_cmd          i_cmd,
    output crcdf_pkg::t_dp_sts          o_sts,
    input  wire  [7:0]                  i_rx_byte,
    input  wire                         i_psel,
    input  wire                         i_penable,
    input  wire                         i_pwrite,
    input  wire  [crcdf_pkg::ADDR_W-1:0] i_paddr,
    input  wire  [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [23:0]                 o_out_tdata,  // payload_byte, err_code, frame_length
    output logic [1:0]                  o_out_tuser,  // kind
    output logic                        o_out_tlast
);

    // Configuration registers.
    logic [7:0]  r_sync0, r_sync1, r_sync2, r_sync3, r_term;
    logic [15:0] r_frame_to, r_hb_to;

    // Frame and timer state.
    logic [crcdf_pkg::LEN_W-1:0]  r_exp_len;
    logic [crcdf_pkg::LEN_W-1:0]  r_byte_idx;
    logic [crcdf_pkg::PAY_AW-1:0] r_rd_idx;
    logic [15:0]                  r_crc;
    logic [7:0]                   r_crc_hi;
    logic [15:0]                  r_idle;
    logic [16:0]                  r_hb;

    // Payload memory with registered read.
    logic [7:0] r_mem [crcdf_pkg::MAX_PAYLOAD];
    logic [7:0] r_rd_data;

    // Output register.
    logic                        r_out_valid;
    crcdf_pkg::t_kind            r_out_kind;
    logic [7:0]                  r_out_pay;
    crcdf_pkg::t_err             r_out_err;
    logic [crcdf_pkg::LEN_W-1:0] r_out_len;
    logic                        r_out_last;

    logic        cfg_wr;
    logic [15:0] idle_inc;
    logic [16:0] hb_inc;
    logic [crcdf_pkg::LEN_W-1:0] byte_idx_inc;
    logic [crcdf_pkg::LEN_W-1:0] rd_idx_inc;

    assign cfg_wr = i_psel && i_penable && i_pwrite;

    // Saturating timer increments and index increments.
    assign idle_inc     = (r_idle == crcdf_pkg::IDLE_SAT) ? r_idle : r_idle + 16'd1;
    assign hb_inc       = (r_hb == crcdf_pkg::HB_SAT) ? r_hb : r_hb + 17'd1;
    assign byte_idx_inc = r_byte_idx + 1'b1;
    assign rd_idx_inc   = crcdf_pkg::LEN_W'(r_rd_idx) + 1'b1;

    // Status toward the controller.
    always_comb begin
        o_sts.sync0_eq = (i_rx_byte == r_sync0);
        o_sts.sync1_eq = (i_rx_byte == r_sync1);
        o_sts.sync2_eq = (i_rx_byte == r_sync2);
        o_sts.sync3_eq = (i_rx_byte == r_sync3);
        o_sts.term_eq  = (i_rx_byte == r_term);
        o_sts.len_ok   = (i_rx_byte != 8'd0) &&
                         (i_rx_byte <= 8'(crcdf_pkg::MAX_PAYLOAD));
        o_sts.crc_ok   = ({r_crc_hi, i_rx_byte} == r_crc);
        o_sts.pay_last = (byte_idx_inc >= r_exp_len);
        o_sts.rd_last  = (rd_idx_inc == r_exp_len);
        o_sts.idle_hit = (idle_inc >= r_frame_to);
        o_sts.hb_over  = (hb_inc > {1'b0, r_hb_to});
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync0    <= 8'd0;
            r_sync1    <= 8'd0;
            r_sync2    <= 8'd0;
            r_sync3    <= 8'd0;
            r_term     <= 8'd0;
            r_frame_to <= 16'd100;
            r_hb_to    <= 16'd1000;
        end else if (cfg_wr) begin
            unique case (crcdf_pkg::t_reg_idx'(i_paddr[4:2]))
                crcdf_pkg::REG_SYNC0:     r_sync0    <= i_pwdata[7:0];
                crcdf_pkg::REG_SYNC1:     r_sync1    <= i_pwdata[7:0];
                crcdf_pkg::REG_SYNC2:     r_sync2    <= i_pwdata[7:0];
                crcdf_pkg::REG_SYNC3:     r_sync3    <= i_pwdata[7:0];
                crcdf_pkg::REG_TERM:      r_term     <= i_pwdata[7:0];
                crcdf_pkg::REG_FRAME_TO:  r_frame_to <= i_pwdata[15:0];
                crcdf_pkg::REG_HEARTBEAT: r_hb_to    <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (crcdf_pkg::t_reg_idx'(i_paddr[4:2]))
            crcdf_pkg::REG_SYNC0:     o_prdata = {24'd0, r_sync0};
            crcdf_pkg::REG_SYNC1:     o_prdata = {24'd0, r_sync1};
            crcdf_pkg::REG_SYNC2:     o_prdata = {24'd0, r_sync2};
            crcdf_pkg::REG_SYNC3:     o_prdata = {24'd0, r_sync3};
            crcdf_pkg::REG_TERM:      o_prdata = {24'd0, r_term};
            crcdf_pkg::REG_FRAME_TO:  o_prdata = {16'd0, r_frame_to};
            crcdf_pkg::REG_HEARTBEAT: o_prdata = {16'd0, r_hb_to};
            default:                  o_prdata = 32'd0;
        endcase
    end

    // Frame state, CRC and timers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len  <= '0;
            r_byte_idx <= '0;
            r_rd_idx   <= '0;
            r_crc      <= crcdf_pkg::CRC_INIT;
            r_crc_hi   <= 8'd0;
            r_idle     <= 16'd0;
            r_hb       <= 17'd0;
        end else begin
            if (i_cmd.len_load) begin
                r_exp_len <= i_rx_byte[crcdf_pkg::LEN_W-1:0];
            end
            if (i_cmd.crc_hi_load) begin
                r_crc_hi <= i_rx_byte;
            end
            if (i_cmd.go_idle) begin
                r_byte_idx <= '0;
                r_crc      <= crcdf_pkg::CRC_INIT;
                r_idle     <= 16'd0;
            end else begin
                if (i_cmd.pay_write) begin
                    r_byte_idx <= byte_idx_inc;
                    r_crc      <= crcdf_pkg::crc_byte(r_crc, i_rx_byte);
                end
                if (i_cmd.tick) begin
                    r_idle <= idle_inc;
                end
            end
            if (i_cmd.hb_clear) begin
                r_hb <= 17'd0;
            end else if (i_cmd.tick) begin
                r_hb <= hb_inc;
            end
            if (i_cmd.burst_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= rd_idx_inc[crcdf_pkg::PAY_AW-1:0];
            end
        end
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_write) begin
            r_mem[r_byte_idx[crcdf_pkg::PAY_AW-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // Output register; a new result may load as the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_err  <= (i_cmd.out_kind == crcdf_pkg::KIND_ERROR) ?
                          i_cmd.out_err : crcdf_pkg::ERR_SYNC;
            r_out_pay  <= (i_cmd.out_kind == crcdf_pkg::KIND_PAYLOAD) ? r_rd_data : 8'd0;
            r_out_len  <= i_cmd.out_len_sel ? r_exp_len : '0;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {7'd0, r_out_len, r_out_err, r_out_pay};
    assign o_out_tuser = r_out_kind;
    assign o_out_tlast = r_out_last;

endmodule

`default_nettype wire

### design/crcdf_ctrl.sv
// Controller of the packet deframer: frame phase state machine and the
// payload read-out sequence. Depends on crcdf_pkg.
`default_nettype none

module crcdf_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_op,
    output logic                o_in_ready,
    input  crcdf_pkg::t_dp_sts  i_sts,
    output crcdf_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYNC1,
        S_SYNC2,
        S_SYNC3,
        S_LEN,
        S_PAY,
        S_CRC1,
        S_CRC2,
        S_TERM,
        S_BURST_RD,
        S_BURST_WR
    } t_state;

    t_state r_state, n_state;
    logic   in_acc;
    logic   in_busy;

    // Items are taken outside the read-out whenever the output can take a result.
    assign in_busy    = (r_state == S_BURST_RD) || (r_state == S_BURST_WR);
    assign o_in_ready = !in_busy && i_sts.out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_kind = crcdf_pkg::KIND_ERROR;
        o_cmd.out_err  = crcdf_pkg::ERR_SYNC;
        n_state       = r_state;

        if (in_acc && (i_in_op == crcdf_pkg::OP_TICK)) begin
            // Tick: advance timers, abort on frame timeout, report lost link.
            o_cmd.tick = 1'b1;
            if (i_sts.idle_hit) begin
                o_cmd.go_idle = 1'b1;
                n_state       = S_IDLE;
            end
            if (i_sts.hb_over) begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_kind = crcdf_pkg::KIND_LOST;
                o_cmd.out_last = 1'b1;
            end
        end else if (in_acc) begin
            // Received byte: advance through the frame.
            unique case (r_state)
                S_IDLE: begin
                    if (i_sts.sync0_eq) begin
                        n_state = S_SYNC1;
                    end
                end
                S_SYNC1, S_SYNC2, S_SYNC3: begin
                    if ((r_state == S_SYNC1 && !i_sts.sync1_eq) ||
                        (r_state == S_SYNC2 && !i_sts.sync2_eq) ||
                        (r_state == S_SYNC3 && !i_sts.sync3_eq)) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = crcdf_pkg::ERR_SYNC;
                        o_cmd.out_last = 1'b1;
                        o_cmd.go_idle  = 1'b1;
                        n_state        = S_IDLE;
                    end else if (r_state == S_SYNC1) begin
                        n_state = S_SYNC2;
                    end else if (r_state == S_SYNC2) begin
                        n_state = S_SYNC3;
                    end else begin
                        n_state = S_LEN;
                    end
                end
                S_LEN: begin
                    if (!i_sts.len_ok) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_err  = crcdf_pkg::ERR_LENGTH;
                        o_cmd.out_last = 1'b1;
                        o_cmd.go_idle  = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.len_load = 1'b1;
                        n_state        = S_PAY;
                    end
                end
                S_PAY: begin
                    o_cmd.pay_write = 1'b1;
                    if (i_sts.pay_last) begin
                        n_state = S_CRC1;
                    end
                end
                S_CRC1: begin
                    o_cmd.crc_hi_load = 1'b1;
                    n_state           = S_CRC2;
                end
                S_CRC2: begin
                    if (!i_sts.crc_ok) begin
                        o_cmd.out_load    = 1'b1;
                        o_cmd.out_err     = crcdf_pkg::ERR_CRC;
                        o_cmd.out_len_sel = 1'b1;
                        o_cmd.out_last    = 1'b1;
                        o_cmd.go_idle     = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        n_state = S_TERM;
                    end
                end
                S_TERM: begin
                    o_cmd.go_idle = 1'b1;
                    if (!i_sts.term_eq) begin
                        o_cmd.out_load    = 1'b1;
                        o_cmd.out_err     = crcdf_pkg::ERR_TERM;
                        o_cmd.out_len_sel = 1'b1;
                        o_cmd.out_last    = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.hb_clear    = 1'b1;
                        o_cmd.burst_start = 1'b1;
                        n_state           = S_BURST_RD;
                    end
                end
                default: begin
                    o_cmd.go_idle = 1'b1;
                    n_state       = S_IDLE;
                end
            endcase
        end else if (r_state == S_BURST_RD) begin
            // Memory read of the current entry is in flight.
            n_state = S_BURST_WR;
        end else if (r_state == S_BURST_WR && i_sts.out_free) begin
            // Hand one payload byte to the output register.
            o_cmd.out_load    = 1'b1;
            o_cmd.out_kind    = crcdf_pkg::KIND_PAYLOAD;
            o_cmd.out_len_sel = 1'b1;
            o_cmd.out_last    = i_sts.rd_last;
            o_cmd.rd_next     = 1'b1;
            n_state           = i_sts.rd_last ? S_IDLE : S_BURST_RD;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### design/crc16_packet_deframer.sv
// A byte or tick is decided in the cycle it is transferred; its one result, if
// any, is in the output register on the next cycle. One item per cycle while
// the output keeps up and no read-out runs. A good terminator starts a payload
// read-out from the payload memory, each byte a registered read and then a
// load into the output register; no input is taken during the read-out.
// Reset (synchronous, active low) returns to idle with default configuration.
`default_nettype none

module crc16_packet_deframer (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [7:0]                   s_axis_tdata,  // rx_byte
    input  wire                          s_axis_tuser,  // op
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [23:0]                  m_axis_tdata,  // payload_byte, err_code, frame_length
    output logic [1:0]                   m_axis_tuser,  // kind
    output logic                         m_axis_tlast,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [crcdf_pkg::ADDR_W-1:0] paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    crcdf_pkg::t_dp_cmd cmd;
    crcdf_pkg::t_dp_sts sts;

    assign pready = 1'b1;

    // Frame controller.
    crcdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath with configuration, CRC, timers, memory and output register.
    crcdf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rx_byte   (s_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser),
        .o_out_tlast (m_axis_tlast)
    );

endmodule

`default_nettype wire

### sim/crcdf_monitor.sv
// Checker for the packet deframer: watches the byte/tick stream, the result stream
// and the APB writes, predicts every result and compares it field by field.
// Depends on crcdf_pkg for the result kinds, error codes and register indexes.
`default_nettype none

module crcdf_monitor (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire  [7:0]                   i_in_data,   // rx_byte
    input  wire                          i_in_user,   // op
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire  [23:0]                  i_out_data,  // payload_byte, err_code, frame_length
    input  wire  [1:0]                   i_out_user,  // kind
    input  wire                          i_out_last,
    input  wire                          i_psel,
    input  wire                          i_penable,
    input  wire                          i_pwrite,
    input  wire                          i_pready,
    input  wire  [crcdf_pkg::ADDR_W-1:0] i_paddr,
    input  wire  [31:0]                  i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import crcdf_pkg::*;

    localparam logic [15:0] CCITT_POLY = 16'h1021;

    typedef enum logic [3:0] {
        RX_IDLE,
        RX_SYNC1,
        RX_SYNC2,
        RX_SYNC3,
        RX_LEN,
        RX_PAYLOAD,
        RX_CRC_HI,
        RX_CRC_LO,
        RX_TERM
    } t_rx_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_err       err;
        logic [6:0] len;
        logic       last;
    } t_deframed;

    // Results predicted but not yet seen on the output.
    t_deframed  due_results[$];
    t_deframed  want;
    int         mismatches = 0;

    // Shadow of the configuration registers.
    logic [7:0]  sync_cfg [4];
    logic [7:0]  term_cfg;
    logic [15:0] frame_to_cfg;
    logic [15:0] heartbeat_cfg;

    // Shadow of the deframer state.
    t_rx_phase   rx_phase;
    logic [6:0]  frame_len;
    logic [6:0]  pay_idx;
    logic [7:0]  pay_mem [MAX_PAYLOAD];
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic [15:0] idle_ms;
    logic [16:0] hb_ms;

    // CRC-16/CCITT-FALSE, one data bit at a time from the MSB.
    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            if (c[15] ^ b[k]) begin
                c = {c[14:0], 1'b0} ^ CCITT_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    task automatic go_idle();
        rx_phase = RX_IDLE;
        pay_idx  = 7'd0;
        crc_acc  = 16'hFFFF;
        idle_ms  = 16'd0;
    endtask

    task automatic push_result(input t_kind k, input logic [7:0] d, input t_err e,
                               input logic [6:0] n, input logic fin);
        t_deframed r;
        r.kind = k;
        r.data = d;
        r.err  = e;
        r.len  = n;
        r.last = fin;
        due_results.push_back(r);
    endtask

    // A framing fault reports one error and drops back to idle.
    task automatic frame_fault(input t_err code, input logic [6:0] n);
        push_result(KIND_ERROR, 8'h00, code, n, 1'b1);
        go_idle();
    endtask

    // Advance the shadow state by one transferred byte or tick.
    task automatic deframe_step(input logic is_tick, input logic [7:0] b);
        if (is_tick) begin
            if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
            if (hb_ms != 17'h1FFFF) hb_ms = hb_ms + 17'd1;
            if (idle_ms >= frame_to_cfg) go_idle();
            // The code field of a connection-lost result is zero.
            if (hb_ms > {1'b0, heartbeat_cfg}) begin
                push_result(KIND_LOST, 8'h00, ERR_SYNC, 7'd0, 1'b1);
            end
        end else begin
            case (rx_phase)
                RX_IDLE: begin
                    if (b == sync_cfg[0]) rx_phase = RX_SYNC1;
                end
                RX_SYNC1: begin
                    if (b != sync_cfg[1]) frame_fault(ERR_SYNC, 7'd0);
                    else rx_phase = RX_SYNC2;
                end
                RX_SYNC2: begin
                    if (b != sync_cfg[2]) frame_fault(ERR_SYNC, 7'd0);
                    else rx_phase = RX_SYNC3;
                end
                RX_SYNC3: begin
                    if (b != sync_cfg[3]) frame_fault(ERR_SYNC, 7'd0);
                    else rx_phase = RX_LEN;
                end
                RX_LEN: begin
                    if (b == 8'd0 || b > MAX_PAYLOAD) begin
                        frame_fault(ERR_LENGTH, 7'd0);
                    end else begin
                        frame_len = b[6:0];
                        rx_phase  = RX_PAYLOAD;
                    end
                end
                RX_PAYLOAD: begin
                    if (pay_idx < MAX_PAYLOAD) pay_mem[pay_idx[5:0]] = b;
                    crc_acc = crc_next(crc_acc, b);
                    pay_idx = pay_idx + 7'd1;
                    if (pay_idx >= frame_len) rx_phase = RX_CRC_HI;
                end
                RX_CRC_HI: begin
                    crc_rx   = {b, 8'h00};
                    rx_phase = RX_CRC_LO;
                end
                RX_CRC_LO: begin
                    crc_rx[7:0] = b;
                    if (crc_rx != crc_acc) frame_fault(ERR_CRC, frame_len);
                    else rx_phase = RX_TERM;
                end
                RX_TERM: begin
                    if (b != term_cfg) begin
                        frame_fault(ERR_TERM, frame_len);
                    end else begin
                        // A good frame clears the heartbeat and releases its payload.
                        hb_ms = 17'd0;
                        for (int i = 0; i < frame_len; i++) begin
                            push_result(KIND_PAYLOAD, pay_mem[i], ERR_SYNC, frame_len,
                                        i == frame_len - 1);
                        end
                        go_idle();
                    end
                end
                default: go_idle();
            endcase
        end
    endtask

    // Results are checked before the input of the same edge is predicted, since a
    // result can never belong to an item transferred at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_cfg      = '{8'h00, 8'h00, 8'h00, 8'h00};
            term_cfg      = 8'h00;
            frame_to_cfg  = 16'd100;
            heartbeat_cfg = 16'd1000;
            frame_len     = 7'd0;
            crc_rx        = 16'd0;
            hb_ms         = 17'd0;
            go_idle();
            due_results.delete();
        end else begin
            // Result transfer.
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: kind=%0d tdata=%06h last=%0d",
                                 i_out_user, i_out_data, i_out_last);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (want.kind != i_out_user || want.data != i_out_data[7:0] ||
                        want.err != i_out_data[9:8] || want.len != i_out_data[16:10] ||
                        want.last != i_out_last || i_out_data[23:17] != 7'd0) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected kind=%0d byte=%02h err=%0d len=%0d last=%0d",
                                     want.kind, want.data, want.err, want.len, want.last);
                            $display("                 got kind=%0d byte=%02h err=%0d len=%0d last=%0d pad=%02h",
                                     i_out_user, i_out_data[7:0], i_out_data[9:8],
                                     i_out_data[16:10], i_out_last, i_out_data[23:17]);
                        end
                    end
                end
            end

            // Byte or tick transfer.
            if (i_in_valid && i_in_ready) begin
                deframe_step(i_in_user == OP_TICK, i_in_data);
            end

            // Register write.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[crcdf_pkg::ADDR_W-1:2]))
                    REG_SYNC0:     sync_cfg[0]   = i_pwdata[7:0];
                    REG_SYNC1:     sync_cfg[1]   = i_pwdata[7:0];
                    REG_SYNC2:     sync_cfg[2]   = i_pwdata[7:0];
                    REG_SYNC3:     sync_cfg[3]   = i_pwdata[7:0];
                    REG_TERM:      term_cfg      = i_pwdata[7:0];
                    REG_FRAME_TO:  frame_to_cfg  = i_pwdata[15:0];
                    REG_HEARTBEAT: heartbeat_cfg = i_pwdata[15:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Top of the packet deframer testbench: clock, reset, APB setup, frame and tick
// stimulus with random idling, and the verdict.
// Depends on crcdf_pkg, crc16_packet_deframer and crcdf_monitor.
`default_nettype none

module tb_top;
    import crcdf_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE       = 8;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SYNC,
        FR_BAD_LEN,
        FR_BAD_CRC,
        FR_BAD_TERM,
        FR_CUT
    } t_frame_style;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [7:0]            s_axis_tdata  = 8'h00;   // rx_byte
    logic                  s_axis_tuser  = OP_BYTE; // op
    logic                  m_axis_tready = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [31:0]           pwdata        = 32'd0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [23:0]           m_axis_tdata;            // payload_byte, err_code, frame_length
    wire  [1:0]            m_axis_tuser;            // kind
    wire                   m_axis_tlast;
    wire  [31:0]           prdata;
    wire                   pready;

    int          fail_total;
    int          results_due;
    int          cycle_count   = 0;
    int          counted_items = 0;
    int          ready_hold    = 0;
    logic        idle_on       = 1'b0;
    logic [7:0]  sync_val [4];
    logic [7:0]  term_val;

    crc16_packet_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    crcdf_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_total),
        .o_pending    (results_due)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: ready, with random stall bursts while idling is on.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_hold    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Reference CRC for building good frames.
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        repeat (8) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // One byte or tick transfer, after an optional idle burst. Valid stays high
    // on return so that back-to-back transfers run without a gap.
    task automatic send_serial(input logic op, input logic [7:0] b, input logic counts);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (counts) counted_items++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_serial(OP_TICK, 8'($urandom), 1'b1);
    endtask

    // Stop sending and wait until every predicted result has been transferred.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [7:0] s0, input logic [7:0] s1,
                                 input logic [7:0] s2, input logic [7:0] s3,
                                 input logic [7:0] term, input logic [15:0] frame_to,
                                 input logic [15:0] heartbeat);
        sync_val = '{s0, s1, s2, s3};
        term_val = term;
        write_reg(REG_SYNC0, {8'd0, s0});
        write_reg(REG_SYNC1, {8'd0, s1});
        write_reg(REG_SYNC2, {8'd0, s2});
        write_reg(REG_SYNC3, {8'd0, s3});
        write_reg(REG_TERM, {8'd0, term});
        write_reg(REG_FRAME_TO, frame_to);
        write_reg(REG_HEARTBEAT, heartbeat);
    endtask

    // Build one frame of the given style and send it, with the odd tick mixed in.
    // For a bad-length frame len_sel is the length byte itself, else the payload
    // length; a negative len_sel picks at random.
    task automatic send_frame(input t_frame_style style, input int len_sel);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        logic [7:0]  pay_b;
        int          n_pay;
        int          pos;
        int          pick;
        crc  = CRC_INIT;
        pick = $urandom_range(0, 99);
        if (len_sel >= 0) n_pay = len_sel;
        else if (pick < 75) n_pay = $urandom_range(1, 8);
        else if (pick < 95) n_pay = $urandom_range(9, 63);
        else n_pay = MAX_PAYLOAD;
        frame_q = {sync_val[0], sync_val[1], sync_val[2], sync_val[3]};
        if (style == FR_BAD_SYNC) begin
            pos = $urandom_range(1, 3);
            frame_q[pos] = sync_val[pos] ^ 8'($urandom_range(1, 255));
            frame_q = frame_q[0:pos];
        end else if (style == FR_BAD_LEN) begin
            if (len_sel >= 0) frame_q.push_back(8'(len_sel));
            else if ($urandom_range(0, 2) == 0) frame_q.push_back(8'd0);
            else frame_q.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        end else begin
            frame_q.push_back(8'(n_pay));
            repeat (n_pay) begin
                pay_b = 8'($urandom);
                frame_q.push_back(pay_b);
                crc = crc_step(crc, pay_b);
            end
            if (style == FR_BAD_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
            frame_q.push_back(crc[15:8]);
            frame_q.push_back(crc[7:0]);
            if (style == FR_BAD_TERM) frame_q.push_back(term_val ^ 8'($urandom_range(1, 255)));
            else frame_q.push_back(term_val);
            if (style == FR_CUT) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
        end
        foreach (frame_q[k]) begin
            if ($urandom_range(0, 29) == 0) send_ticks(1);
            send_serial(OP_BYTE, frame_q[k], 1'b1);
        end
    endtask

    // Mostly well-formed frames, the rest faults, line noise and tick bursts.
    task automatic run_random(input int quota);
        int start;
        int r;
        start = counted_items;
        while (counted_items - start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 52) send_frame(FR_GOOD, -1);
            else if (r < 58) send_frame(FR_BAD_SYNC, -1);
            else if (r < 63) send_frame(FR_BAD_LEN, -1);
            else if (r < 71) send_frame(FR_BAD_CRC, -1);
            else if (r < 77) send_frame(FR_BAD_TERM, -1);
            else if (r < 83) send_frame(FR_CUT, -1);
            else if (r < 90) begin
                repeat ($urandom_range(1, 4)) send_serial(OP_BYTE, 8'($urandom), 1'b0);
            end else begin
                send_ticks($urandom_range(1, 6));
            end
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored noise, a minimal good frame, sync and length faults,
        // and ticks running past a short heartbeat limit.
        apply_setting(8'hFF, 8'h00, 8'hAA, 8'h55, 8'h7E, 16'hFFFF, 16'd2);
        send_serial(OP_BYTE, 8'h12, 1'b0);
        send_frame(FR_GOOD, 1);
        send_frame(FR_BAD_SYNC, -1);
        send_frame(FR_BAD_LEN, 0);
        send_frame(FR_BAD_LEN, MAX_PAYLOAD + 1);
        send_ticks(3);
        wait_drained();

        // Random sync pattern, short frame timeout, moderate heartbeat.
        idle_on <= 1'b1;
        apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'd6, 16'd40);
        send_frame(FR_GOOD, MAX_PAYLOAD);
        run_random(60);
        wait_drained();

        // All-zero bytes, and the smallest limits: every tick aborts any frame.
        apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd1, 16'd1);
        run_random(60);
        wait_drained();

        // All-ones bytes, and the largest limits.
        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        run_random(60);
        wait_drained();

        // Closing stretch with no idling on either side.
        idle_on <= 1'b0;
        apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom_range(2, 30)),
                      16'($urandom_range(5, 100)));
        run_random(60);
        wait_drained();

        if (fail_total == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
design/crcdf_pkg.sv
design/crcdf_dp.sv
design/crcdf_ctrl.sv
design/crc16_packet_deframer.sv
sim/crcdf_monitor.sv
sim/tb_top.sv
